// File: rtl/dnat_pkg.sv
package dnat_pkg;

    localparam int unsigned PORT_W            = 16;
    localparam int unsigned ADDR_W            = 64;
    localparam int unsigned V4_W              = 32;
    localparam int unsigned CFG_IDX_W         = 3;
    localparam int unsigned CFG_DATA_W        = 64;
    localparam int unsigned TRACK_ENTRIES_DEF = 65536;
    localparam int unsigned QUEUE_DEPTH       = 2;

    // Power-on values of the configuration registers.
    localparam logic [V4_W-1:0]   RST_REDIR_V4       = 32'h4D58_0808;
    localparam logic [ADDR_W-1:0] RST_REDIR_V6_UPPER = 64'h2A02_06B8_0000_0000;
    localparam logic [ADDR_W-1:0] RST_REDIR_V6_LOWER = 64'h0000_0000_FEED_00FF;
    localparam logic [PORT_W-1:0] RST_REDIR_PORT     = 16'd1253;
    localparam logic [PORT_W-1:0] RST_QUERY_PORT     = 16'd53;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REDIR_V4       = 3'd0,
        CFG_REDIR_V6_UPPER = 3'd1,
        CFG_REDIR_V6_LOWER = 3'd2,
        CFG_REDIR_PORT     = 3'd3,
        CFG_QUERY_PORT     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [V4_W-1:0]   redirect_ipv4_addr;
        logic [ADDR_W-1:0] redirect_ipv6_upper;
        logic [ADDR_W-1:0] redirect_ipv6_lower;
        logic [PORT_W-1:0] redirect_port;
        logic [PORT_W-1:0] query_port;
    } t_cfg;

    typedef struct packed {
        logic              is_outbound;
        logic              is_udp;
        logic              is_ipv6;
        logic [PORT_W-1:0] source_port;
        logic [PORT_W-1:0] dest_port;
        logic [ADDR_W-1:0] source_addr_high;
        logic [ADDR_W-1:0] source_addr_low;
        logic [ADDR_W-1:0] dest_addr_high;
        logic [ADDR_W-1:0] dest_addr_low;
    } t_req;

    typedef struct packed {
        logic [PORT_W-1:0] out_source_port;
        logic [PORT_W-1:0] out_dest_port;
        logic [ADDR_W-1:0] out_source_high;
        logic [ADDR_W-1:0] out_source_low;
        logic [ADDR_W-1:0] out_dest_high;
        logic [ADDR_W-1:0] out_dest_low;
        logic              was_rewritten;
    } t_rsp;

    typedef enum logic [1:0] {
        KIND_PASS     = 2'd0,
        KIND_REDIRECT = 2'd1,
        KIND_RESTORE  = 2'd2
    } t_kind;

    // One classified packet on its way from the front to the back.
    typedef struct packed {
        t_kind             kind;
        logic [PORT_W-1:0] slot;
        t_req              req;
    } t_cmd;

    // One row of the translation table.
    typedef struct packed {
        logic              valid;
        logic              ipv6;
        logic [PORT_W-1:0] port_tag;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
    } t_entry;

endpackage

// File: rtl/dnat_beat_if.sv
interface dnat_beat_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/dnat_fifo.sv
module dnat_fifo
    import dnat_pkg::*;
#(
    parameter type t_data = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_data o_data,
    output logic  o_empty
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_data            r_data [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_data[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wptr] <= i_data;
        end
    end

endmodule

// File: rtl/dnat_front.sv
module dnat_front
    import dnat_pkg::*;
#(
    parameter int unsigned TRACK_ENTRIES = TRACK_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_clear_busy,
    dnat_beat_if.sink   i_req,
    output logic        o_push,
    output t_cmd        o_cmd,
    input  logic        i_full
);

    // Table slot = key mod TRACK_ENTRIES, by multiplying with 2^32 / TRACK_ENTRIES
    // rounded up, a scaled reciprocal. For 16-bit keys the quotient is exact.
    localparam longint unsigned RECIP =
        ((64'd1 << 32) + 64'(TRACK_ENTRIES) - 64'd1) / 64'(TRACK_ENTRIES);
    localparam int unsigned RECIP_W = $clog2(RECIP + 64'd1);
    localparam int unsigned PROD_W  = PORT_W + RECIP_W;
    localparam int unsigned QUO_W   = PROD_W - 32;

    logic                r_s1_valid;
    t_req                r_s1_req;
    t_kind               r_s1_kind;
    logic [PORT_W-1:0]   r_s1_key;
    logic [PROD_W-1:0]   r_s1_prod;

    t_req                req;
    logic                redirect, restore, s1_free, accept;
    t_kind               kind;
    logic [PORT_W-1:0]   key;
    logic [QUO_W-1:0]    quo;
    logic [PORT_W-1:0]   quo_times_n;

    assign req      = i_req.payload;
    assign redirect = req.is_udp && req.is_outbound && (req.dest_port == i_cfg.query_port);
    assign restore  = req.is_udp && !req.is_outbound
                      && (req.source_port == i_cfg.redirect_port);
    assign kind     = redirect ? KIND_REDIRECT : (restore ? KIND_RESTORE : KIND_PASS);
    assign key      = redirect ? req.source_port : req.dest_port;

    assign o_push      = r_s1_valid && !i_full;
    assign s1_free     = !r_s1_valid || !i_full;
    assign i_req.ready = s1_free && !i_clear_busy;
    assign accept      = i_req.valid && i_req.ready;

    assign quo         = r_s1_prod[PROD_W-1:32];
    assign quo_times_n = PORT_W'(32'(quo) * 32'(TRACK_ENTRIES));

    always_comb begin
        o_cmd      = '0;
        o_cmd.kind = r_s1_kind;
        o_cmd.slot = r_s1_key - quo_times_n;
        o_cmd.req  = r_s1_req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_req  <= req;
            r_s1_kind <= kind;
            r_s1_key  <= key;
            r_s1_prod <= PROD_W'(key) * PROD_W'(RECIP);
        end
    end

endmodule

// File: rtl/dnat_back.sv
module dnat_back
    import dnat_pkg::*;
#(
    parameter int unsigned TRACK_ENTRIES = TRACK_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    output logic        o_clear_busy,
    input  logic        i_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    dnat_beat_if.source o_rsp
);

    localparam int unsigned IDX_W = $clog2(TRACK_ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TRACK_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_clr_idx, n_clr_idx;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_rsp;
    t_cmd              r_cmd;
    t_entry            r_rd_data;
    t_entry            r_mem [TRACK_ENTRIES];

    logic              rd_en, mem_we, load_out, out_free, hit, wr_needed;
    logic [IDX_W-1:0]  mem_waddr;
    t_entry            mem_wdata, upd_entry;
    t_rsp              rsp;

    assign out_free     = !r_out_valid || o_rsp.ready;
    assign o_clear_busy = (r_state == S_CLEAR);
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.payload = r_rsp;

    // Rewrite of the packet held in r_cmd against the row just read.
    always_comb begin
        rsp.out_source_port = r_cmd.req.source_port;
        rsp.out_dest_port   = r_cmd.req.dest_port;
        rsp.out_source_high = r_cmd.req.source_addr_high;
        rsp.out_source_low  = r_cmd.req.source_addr_low;
        rsp.out_dest_high   = r_cmd.req.dest_addr_high;
        rsp.out_dest_low    = r_cmd.req.dest_addr_low;
        rsp.was_rewritten   = 1'b0;
        upd_entry           = r_rd_data;
        wr_needed           = 1'b0;
        hit = r_rd_data.valid && (r_rd_data.port_tag == r_cmd.req.dest_port);
        case (r_cmd.kind)
            KIND_REDIRECT: begin
                upd_entry.valid    = 1'b1;
                upd_entry.ipv6     = r_cmd.req.is_ipv6;
                upd_entry.port_tag = r_cmd.req.source_port;
                if (r_cmd.req.is_ipv6) begin
                    upd_entry.addr_high = r_cmd.req.dest_addr_high;
                    upd_entry.addr_low  = r_cmd.req.dest_addr_low;
                    rsp.out_dest_high   = i_cfg.redirect_ipv6_upper;
                    rsp.out_dest_low    = i_cfg.redirect_ipv6_lower;
                end else begin
                    upd_entry.addr_high = '0;
                    upd_entry.addr_low  = ADDR_W'(r_cmd.req.dest_addr_low[V4_W-1:0]);
                    rsp.out_dest_high   = '0;
                    rsp.out_dest_low    = ADDR_W'(i_cfg.redirect_ipv4_addr);
                end
                rsp.out_dest_port = i_cfg.redirect_port;
                rsp.was_rewritten = 1'b1;
                wr_needed         = 1'b1;
            end
            KIND_RESTORE: begin
                if (hit) begin
                    upd_entry.valid     = 1'b0;
                    rsp.out_source_port = i_cfg.query_port;
                    if (r_rd_data.ipv6 == r_cmd.req.is_ipv6) begin
                        rsp.out_source_high = r_rd_data.addr_high;
                        rsp.out_source_low  = r_rd_data.addr_low;
                    end
                    rsp.was_rewritten = 1'b1;
                    wr_needed         = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_out_valid = r_out_valid && !o_rsp.ready;
        o_pop       = 1'b0;
        rd_en       = 1'b0;
        load_out    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_clr_idx;
        mem_wdata   = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == IDX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    rd_en   = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    mem_we      = wr_needed;
                    mem_waddr   = r_cmd.slot[IDX_W-1:0];
                    mem_wdata   = upd_entry;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (load_out) begin
            r_rsp <= rsp;
        end
    end

    // Translation table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[i_cmd.slot[IDX_W-1:0]];
        end
    end

endmodule

// File: rtl/dns_redirect_nat_table_unit.sv
// DNS redirect NAT table. Each input beat carries the parsed header fields of
// one packet and yields exactly one output beat with the rewritten fields, in
// order. Outbound UDP packets to the query port are logged in a table indexed
// by source port (mod TRACK_ENTRIES) and sent to the redirect address and port;
// inbound UDP replies from the redirect port that hit a valid, tag-matching
// entry get the query port back as source port, the original server address
// when the IP version matches, and free the entry. was_rewritten flags every
// packet whose checksums must be recomputed. After reset the block clears
// the table (one row per cycle) and holds i_req.ready low meanwhile;
// configuration writes are taken at any time but must only be issued while
// no packet is in flight. The back end takes one packet at a time and
// reads its table row before it writes it back; each output beat passes
// the front register, the queue, the table read and the output register.
module dns_redirect_nat_table_unit
    import dnat_pkg::*;
#(
    parameter int unsigned TRACK_ENTRIES = TRACK_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dnat_beat_if.sink             i_req,
    dnat_beat_if.source           o_rsp
);

    t_cfg  r_cfg;
    logic  clear_busy;
    logic  q_push, q_full, q_pop, q_empty;
    t_cmd  q_wdata, q_rdata;

    // Configuration registers. Writes to indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.redirect_ipv4_addr  <= RST_REDIR_V4;
            r_cfg.redirect_ipv6_upper <= RST_REDIR_V6_UPPER;
            r_cfg.redirect_ipv6_lower <= RST_REDIR_V6_LOWER;
            r_cfg.redirect_port       <= RST_REDIR_PORT;
            r_cfg.query_port          <= RST_QUERY_PORT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REDIR_V4:       r_cfg.redirect_ipv4_addr  <= i_cfg_data[V4_W-1:0];
                CFG_REDIR_V6_UPPER: r_cfg.redirect_ipv6_upper <= i_cfg_data;
                CFG_REDIR_V6_LOWER: r_cfg.redirect_ipv6_lower <= i_cfg_data;
                CFG_REDIR_PORT:     r_cfg.redirect_port       <= i_cfg_data[PORT_W-1:0];
                CFG_QUERY_PORT:     r_cfg.query_port          <= i_cfg_data[PORT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front classifies each packet and works out its table slot.
    dnat_front #(
        .TRACK_ENTRIES (TRACK_ENTRIES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_clear_busy (clear_busy),
        .i_req        (i_req),
        .o_push       (q_push),
        .o_cmd        (q_wdata),
        .i_full       (q_full)
    );

    // A short queue lets the front keep taking beats while the back is busy.
    dnat_fifo #(
        .t_data (t_cmd)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // The back owns the table: it reads the slot, rewrites the packet and
    // updates the row, then hands the result to the output register.
    dnat_back #(
        .TRACK_ENTRIES (TRACK_ENTRIES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .o_clear_busy (clear_busy),
        .i_empty      (q_empty),
        .i_cmd        (q_rdata),
        .o_pop        (q_pop),
        .o_rsp        (o_rsp)
    );

endmodule
